[rtl/xabc_weyl_prng_word_assert.svh]
// assertion macros shared by the prng word block
`ifndef XABC_WEYL_PRNG_WORD_ASSERT_SVH
`define XABC_WEYL_PRNG_WORD_ASSERT_SVH

// same-cycle implication, clocked by clk, off while rst_n is low
`define XABC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, clocked by clk, off while rst_n is low
`define XABC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/xabc_pkg.sv]
// shared types and constants of the weyl prng word block
package xabc_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned WARM_W = 6;

  localparam logic [BYTE_W-1:0] WEYL_INC     = 8'd151;
  localparam logic [WARM_W-1:0] WARMUP_WORDS = 6'd32;

  // action codes of an input item
  localparam logic ACT_NEXT = 1'b0;
  localparam logic ACT_SEED = 1'b1;

  typedef struct packed {
    logic [BYTE_W-1:0] weyl;
    logic [BYTE_W-1:0] a;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] c;
  } mix_state_t;

endpackage

[rtl/xabc_in_if.sv]
// input channel: action and seed word with valid/ready
interface xabc_in_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [xabc_pkg::WORD_W-1:0] seed_value;

  modport source (output valid, output action, output seed_value, input ready);
  modport sink (input valid, input action, input seed_value, output ready);
endinterface

[rtl/xabc_out_if.sv]
// result channel: one random word with valid/ready
interface xabc_out_if;
  logic                        valid;
  logic                        ready;
  logic [xabc_pkg::WORD_W-1:0] random_word;

  modport source (output valid, output random_word, input ready);
  modport sink (input valid, input random_word, output ready);
endinterface

[rtl/xabc_weyl_prng_word.sv]
// Weyl-counter byte prng delivering 32-bit words.
// in_item (sink): action 0 asks for the next word, action 1 loads
// seed_value (byte 0 to a, 1 to b, 2 to c, 3 to the counter).
// out_item (source): random_word, first generated byte in bits 7:0.
// A next item is turned into a word in the cycle it is accepted; the word
// sits in the output register from the next cycle on.
// Throughput is one next item per cycle while no warm-up runs and the
// receiver takes each word; four byte steps run unrolled in one combinational
// pass between the state registers. A seed item gives no result; after
// loading it runs WARMUP_WORDS (32) discarded words, one per cycle, so
// in_item.ready stays low until the warm-up count is back to zero.
// When the receiver stalls the output register holds its word, and a new
// next item is taken only once that word leaves (ready passes through
// in the same cycle). Seed items are still taken during a stall.
// Reset clears the counter, mixing bytes and warm-up count to zero and
// empties the output register.
module xabc_weyl_prng_word (
  input  logic        clk,
  input  logic        rst_n,
  xabc_in_if.sink     in_item,
  xabc_out_if.source  out_item
);
  import xabc_pkg::*;

  mix_state_t         st_r, st_nxt;
  mix_state_t         mix_st;
  logic [WORD_W-1:0]  mix_word;
  logic [WARM_W-1:0]  warm_left_r, warm_left_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]  out_word_r, out_word_nxt;
  logic               in_fire;
  logic               warm_busy;
  logic               out_free;

  xabc_mix u_mix (
    .st_i   (st_r),
    .st_o   (mix_st),
    .word_o (mix_word)
  );

  assign warm_busy = (warm_left_r != '0);
  assign out_free  = !out_valid_r || out_item.ready;
  // a seed item needs no output slot
  assign in_item.ready = !warm_busy && (out_free || (in_item.action == ACT_SEED));
  assign in_fire       = in_item.valid && in_item.ready;

  always_comb begin
    st_nxt        = st_r;
    warm_left_nxt = warm_left_r;
    out_valid_nxt = out_valid_r && !out_item.ready;
    out_word_nxt  = out_word_r;
    if (warm_busy) begin
      st_nxt        = mix_st;
      warm_left_nxt = warm_left_r - 1'b1;
    end else if (in_fire) begin
      if (in_item.action == ACT_SEED) begin
        st_nxt.a      = in_item.seed_value[BYTE_W-1:0];
        st_nxt.b      = in_item.seed_value[2*BYTE_W-1:BYTE_W];
        st_nxt.c      = in_item.seed_value[3*BYTE_W-1:2*BYTE_W];
        st_nxt.weyl   = in_item.seed_value[4*BYTE_W-1:3*BYTE_W];
        warm_left_nxt = WARMUP_WORDS;
      end else begin
        st_nxt        = mix_st;
        out_valid_nxt = 1'b1;
        out_word_nxt  = mix_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      warm_left_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      warm_left_r <= warm_left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  assign out_item.valid       = out_valid_r;
  assign out_item.random_word = out_word_r;

`include "xabc_weyl_prng_word_assert.svh"

  `XABC_ASSERT_NEXT(a_seed_loads_warmup, in_fire && (in_item.action == ACT_SEED), warm_left_r == WARMUP_WORDS, "warm-up count not loaded by seed")
  `XABC_ASSERT_NEXT(a_warmup_counts_down, warm_busy, warm_left_r == WARM_W'($past(warm_left_r) - 1'b1), "warm-up count did not step down")
  `XABC_ASSERT_NEXT(a_seed_no_result, in_fire && (in_item.action == ACT_SEED), out_valid_r == $past(out_valid_r && !out_item.ready), "seed item produced a result")
  `XABC_ASSERT_SAME(a_no_take_in_warmup, warm_busy, !in_fire, "item taken during warm-up")

endmodule

[rtl/xabc_mix.sv]
// four unrolled byte steps of the generator, producing one word and the next state
module xabc_mix (
  input  xabc_pkg::mix_state_t         st_i,
  output xabc_pkg::mix_state_t         st_o,
  output logic [xabc_pkg::WORD_W-1:0]  word_o
);
  import xabc_pkg::*;

  mix_state_t        st_s [0:4];
  logic [BYTE_W-1:0] rot_b [0:3];
  logic [BYTE_W-1:0] byte_s [0:3];

  always_comb begin
    st_s[0] = st_i;
    for (int k = 0; k < 4; k++) begin
      st_s[k+1].weyl = st_s[k].weyl + WEYL_INC;
      st_s[k+1].a    = st_s[k].a ^ st_s[k].c ^ st_s[k+1].weyl;
      st_s[k+1].b    = st_s[k].b + st_s[k+1].a;
      // rotate left by 7 is rotate right by 1
      rot_b[k]       = {st_s[k+1].b[0], st_s[k+1].b[BYTE_W-1:1]};
      st_s[k+1].c    = (st_s[k].c + rot_b[k]) ^ st_s[k+1].a;
      byte_s[k]      = st_s[k+1].c ^ st_s[k+1].b;
    end
  end

  // first byte in the low bits
  assign word_o = {byte_s[3], byte_s[2], byte_s[1], byte_s[0]};
  assign st_o   = st_s[4];

endmodule

[bench/xabc_weyl_prng_word_test.sv]
// testbench for the weyl prng word block: directed seeds, random traffic and output stalls
module xabc_weyl_prng_word_test;
  import xabc_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 40;

  logic clk = 1'b0;
  logic rst_n;

  xabc_in_if  in_bus ();
  xabc_out_if out_bus ();

  xabc_weyl_prng_word u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_bus),
    .out_item (out_bus)
  );

  mix_state_t        gen_state;
  logic [WORD_W-1:0] pending_words[$];

  bit src_idle_on;
  bit snk_idle_on;
  int hold_request;
  int fail_count;
  int next_sent;
  int seed_sent;
  int words_checked;
  int idle_cycles;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // one byte step of the generator on the mirrored state
  function automatic logic [BYTE_W-1:0] gen_byte();
    logic [BYTE_W-1:0] rot;
    gen_state.weyl = gen_state.weyl + WEYL_INC;
    gen_state.a = gen_state.a ^ gen_state.c ^ gen_state.weyl;
    gen_state.b = gen_state.b + gen_state.a;
    // rotate left by 7 is rotate right by 1
    rot = {gen_state.b[0], gen_state.b[BYTE_W-1:1]};
    gen_state.c = (gen_state.c + rot) ^ gen_state.a;
    return gen_state.c ^ gen_state.b;
  endfunction

  function automatic logic [WORD_W-1:0] gen_word();
    logic [WORD_W-1:0] w;
    w = '0;
    for (int k = 0; k < 4; k++) begin
      w[8*k +: 8] = gen_byte();
    end
    return w;
  endfunction

  function automatic void load_seed(logic [WORD_W-1:0] seed);
    logic [WORD_W-1:0] discard;
    gen_state.a = seed[7:0];
    gen_state.b = seed[15:8];
    gen_state.c = seed[23:16];
    gen_state.weyl = seed[31:24];
    for (int i = 0; i < int'(WARMUP_WORDS); i++) begin
      discard = gen_word();
    end
  endfunction

  // drives one item from a falling edge and returns at the falling edge after it is taken
  task automatic send_item(input logic act, input logic [WORD_W-1:0] seed);
    int gap;
    if (src_idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 15);
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.action <= act;
    in_bus.seed_value <= seed;
    do @(posedge clk); while (!in_bus.ready);
    if (act == ACT_SEED) begin
      load_seed(seed);
      seed_sent++;
    end else begin
      pending_words.push_back(gen_word());
      next_sent++;
    end
    @(negedge clk);
  endtask

  task automatic send_next();
    send_item(ACT_NEXT, $urandom());
  endtask

  task automatic test_reset_sequence();
    // words straight out of the all-zero reset state
    repeat (4) send_next();
  endtask

  task automatic test_seed_corners();
    logic [WORD_W-1:0] corners[7];
    corners = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_00FF, 32'hFF00_0000,
                32'h8080_8080, 32'h0101_0101, 32'h7F7F_7F7F};
    foreach (corners[i]) begin
      send_item(ACT_SEED, corners[i]);
      send_next();
      send_next();
    end
    // seed right after seed, only the last one counts
    send_item(ACT_SEED, 32'h1234_5678);
    send_item(ACT_SEED, 32'hA5C3_0F96);
    send_next();
  endtask

  task automatic random_item();
    int r;
    logic [WORD_W-1:0] seed;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      seed = $urandom();
      if ($urandom_range(0, 3) == 0) seed = $urandom_range(0, 1) ? '1 : '0;
      send_item(ACT_SEED, seed);
    end else begin
      send_next();
    end
  endtask

  task automatic test_random_traffic(input int count);
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;
    repeat (count) random_item();
  endtask

  task automatic test_backpressure_fill();
    snk_idle_on = 1'b0;
    src_idle_on = 1'b0;
    hold_request = HOLD_CYCLES;
    // one word fills the output register, a seed still gets in, then input stalls
    send_next();
    send_item(ACT_SEED, $urandom());
    repeat (12) send_next();
  endtask

  task automatic test_steady_stream(input int count);
    src_idle_on = 1'b0;
    snk_idle_on = 1'b0;
    repeat (count) random_item();
  endtask

  task automatic finish_run();
    in_bus.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d next items and %0d seed items (corners, back-to-back seeds,",
             next_sent, seed_sent);
    $display("  reset-state words, long output stall), %0d words checked", words_checked);
    if (fail_count == 0) begin
      $display("** xabc_weyl_prng_word: PASSED **");
    end else begin
      $display("** xabc_weyl_prng_word: FAILED **");
    end
    $finish;
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_words.size() == 0) begin
        $error("random_word: expected none, actual %h", out_bus.random_word);
        fail_count++;
      end else begin
        if (out_bus.random_word !== pending_words[0]) begin
          $error("random_word: expected %h, actual %h", pending_words[0],
                 out_bus.random_word);
          fail_count++;
        end
        void'(pending_words.pop_front());
        words_checked++;
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("** xabc_weyl_prng_word: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: random stall bursts and one long hold on request
  initial begin : sink_driver
    int burst;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        burst = hold_request;
        hold_request = 0;
        out_bus.ready <= 1'b0;
        repeat (burst) @(negedge clk);
        out_bus.ready <= 1'b1;
      end else if (snk_idle_on && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 15);
        out_bus.ready <= 1'b0;
        repeat (burst) @(negedge clk);
        out_bus.ready <= 1'b1;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  initial begin : main_seq
    in_bus.valid = 1'b0;
    in_bus.action = ACT_NEXT;
    in_bus.seed_value = '0;
    rst_n = 1'b0;
    gen_state = '0;
    src_idle_on = 1'b0;
    snk_idle_on = 1'b0;
    hold_request = 0;
    fail_count = 0;
    next_sent = 0;
    seed_sent = 0;
    words_checked = 0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_sequence();
    test_seed_corners();
    test_random_traffic(1000);
    test_backpressure_fill();
    test_random_traffic(150);
    test_steady_stream(250);
    finish_run();
  end

endmodule
